// ===== hdl/assert_macros.svh =====
// assertion macros for the keyed record table rtl
// depends on clk_i and rst_ni being present in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KRT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define KRT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`else

`define KRT_ASSERT(lbl, expr, msg)

`define KRT_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== hdl/krt_pkg.sv =====
// shared types and codes for the keyed record table
// no dependencies
package krt_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam logic [9:0] SCORE_MAX = 10'd1000;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
    logic [9:0]  score;
  } rec_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_SHIFT_RD = 6'b001000,
    S_SHIFT_WR = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

endpackage

// ===== hdl/keyed_record_table_unit.sv =====
// keyed record table: unsorted record store with linear id search
// depends on krt_pkg and assert_macros.svh
//
// usage
// - input beats on the s_axis group: tuser carries the operation (insert,
//   delete, lookup; code three acts as lookup), tdata carries id, age, score
// - one result beat per input beat on the m_axis group: tuser carries the
//   status, tdata carries slot index, found age, found score and entry count
// - every operation walks the stored entries through one memory read port
//   and one id comparator, reading then comparing each entry visited; a delete
//   then moves each later entry down one slot, reading then writing each one
// - s_axis_tready_o is high only while no operation is in progress; a new beat
//   may be taken while the previous result still waits in the output register
// - when the receiver stalls, the finished result waits inside and the
//   output register holds its beat until taken
// - reset empties the table at once (entry count zero); the memory contents
//   are not cleared and are never read before being written
`include "assert_macros.svh"

module keyed_record_table_unit
  import krt_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] key_id, [23:16] rec_age, [33:24] rec_score, [39:34] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [6:0] slot_index, [14:7] found_age, [24:15] found_score,
  // [32:25] entry_count, [39:33] zero
  output logic [39:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e        state_q, state_d;
  logic [1:0]    op_q, op_d;
  rec_t          key_q, key_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] idx_inc;

  logic [1:0]    res_status_q, res_status_d;
  logic [AW-1:0] res_slot_q, res_slot_d;
  logic [7:0]    res_age_q, res_age_d;
  logic [9:0]    res_score_q, res_score_d;

  logic          out_valid_q, out_valid_d;
  logic [39:0]   out_data_q, out_data_d;
  logic [1:0]    out_user_q, out_user_d;

  rec_t          mem [CAPACITY];
  rec_t          rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          s_fire;
  logic [9:0]    in_score;
  logic [31:0]   slot_w;
  logic [31:0]   count_w;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_score        = (s_axis_tdata_i[33:24] > SCORE_MAX) ? SCORE_MAX
                                                               : s_axis_tdata_i[33:24];
  assign idx_inc         = idx_q + CW'(1);
  assign slot_w          = 32'(res_slot_q);
  assign count_w         = 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_age_d    = res_age_q;
    res_score_d  = res_score_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[AW-1:0];
    mem_wdata    = rd_q;
    mem_raddr    = idx_q[AW-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          op_d      = s_axis_tuser_i;
          key_d     = '{id: s_axis_tdata_i[15:0], age: s_axis_tdata_i[23:16],
                        score: in_score};
          idx_d     = '0;
          state_d   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        res_slot_d  = '0;
        res_age_d   = '0;
        res_score_d = '0;
        if (idx_q == count_q) begin
          state_d = S_DONE;
          if (op_q == MODE_INSERT) begin
            if (count_q == CAP_C) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = count_q[AW-1:0];
              mem_wdata    = key_q;
              res_status_d = ST_OK;
              res_slot_d   = count_q[AW-1:0];
              count_d      = count_q + CW'(1);
            end
          end else begin
            res_status_d = ST_MISS;
          end
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (rd_q.id == key_q.id) begin
          res_slot_d  = idx_q[AW-1:0];
          res_age_d   = '0;
          res_score_d = '0;
          case (op_q)
            MODE_INSERT: begin
              res_status_d = ST_DUP;
              res_slot_d   = '0;
              state_d      = S_DONE;
            end
            MODE_DELETE: begin
              res_status_d = ST_OK;
              state_d      = S_SHIFT_RD;
            end
            default: begin
              res_status_d = ST_OK;
              res_age_d    = rd_q.age;
              res_score_d  = rd_q.score;
              state_d      = S_DONE;
            end
          endcase
        end else begin
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        mem_raddr = idx_inc[AW-1:0];
        if (idx_inc == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rd_q;
        idx_d     = idx_inc;
        state_d   = S_SHIFT_RD;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_user_d  = res_status_q;
          out_data_d  = {7'b0, count_w[7:0], res_score_q, res_age_q, slot_w[6:0]};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_age_q    <= res_age_d;
    res_score_q  <= res_score_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `KRT_ASSERT(a_count_bound, count_q <= CAP_C, "entry count above capacity")
  `KRT_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `KRT_ASSERT(a_shift_in_range, (state_q != S_SHIFT_RD) || (idx_q < count_q), "bad shift index")
  `KRT_ASSERT_NEXT(a_accept_starts_scan, s_fire, state_q == S_SCAN_RD, "accept without scan")

endmodule
